FILE: hw/rtl/gnfs_pkg.sv
// package for the nearest free 2x2 slot search block
// grid sizes, item kinds, ring offsets; no dependencies
package gnfs_pkg;
    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 32;
    localparam int XW = $clog2(MAX_COLS);
    localparam int YW = $clog2(MAX_ROWS);
    localparam int CW = XW + YW;
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int QW = $clog2(CELLS + 1);

    typedef enum logic [1:0] {
        K_WRITE  = 2'd0,
        K_SEARCH = 2'd1,
        K_CLAIM  = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    localparam logic [1:0] RA_COLS = 2'd0;
    localparam logic [1:0] RA_ROWS = 2'd1;

    // ring L,TL,T,TR,R,BR,B,BL: dx code and dy code, 0 none, 1 plus, 2 minus
    function automatic logic [1:0] ring_dx(input logic [2:0] r);
        case (r)
            3'd0, 3'd1, 3'd7: ring_dx = 2'd2;
            3'd3, 3'd4, 3'd5: ring_dx = 2'd1;
            default:          ring_dx = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] ring_dy(input logic [2:0] r);
        case (r)
            3'd1, 3'd2, 3'd3: ring_dy = 2'd1;
            3'd5, 3'd6, 3'd7: ring_dy = 2'd2;
            default:          ring_dy = 2'd0;
        endcase
    endfunction
endpackage

FILE: hw/rtl/gnfs_cfg.sv
// configuration registers cols_in_use and rows_in_use over apb
// depends on gnfs_pkg
module gnfs_cfg
    import gnfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [XW:0] o_cols,
    output logic [YW:0] o_rows
);
    logic [5:0] r_cols, r_rows;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[2] ? RA_ROWS : RA_COLS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 6'd26;
            r_rows <= 6'd18;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            if (w_idx == RA_COLS) r_cols <= pwdata[5:0];
            else r_rows <= pwdata[5:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'd0) prdata = {26'd0, (w_idx == RA_COLS) ? r_cols : r_rows};
    end

    assign o_cols = (r_cols > 6'(MAX_COLS)) ? (XW+1)'(MAX_COLS) : r_cols[XW:0];
    assign o_rows = (r_rows > 6'(MAX_ROWS)) ? (YW+1)'(MAX_ROWS) : r_rows[YW:0];
endmodule

FILE: hw/rtl/grid_nearest_free_slot_bfs.sv
// Single-issue block: one item at a time, and no new beat is taken until the result beat
// has left. After reset the occupancy map is cleared at one cell per cycle, so the input
// is held off until that clear is done. A write passes through S_WR and S_OUT, an unused
// kind goes straight to S_OUT, and a claim checks its 2x2 block in S_BLK and, when the
// block is placed, writes it in S_WR. A search first clears the visited map at one cell
// per cycle and pushes the start cell, then for each dequeued cell fetches it and reads
// its 2x2 block through the one occupancy read port, and checks each in-grid ring
// neighbour through the visited map port. Outside cells count as occupied.
// depends on gnfs_pkg, gnfs_cfg
module grid_nearest_free_slot_bfs
    import gnfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // kind[1:0] cell_x[6:2] cell_y[11:7] occupied[12]
                                   // start_side[14:13] turn_dir[15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[0] found_x[5:1] found_y[10:6]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CLR   = 8'b00000010,
        S_DEQ   = 8'b00000100,
        S_BLK   = 8'b00001000,
        S_NB    = 8'b00010000,
        S_NBCHK = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_WR    = 8'b10000000
    } t_state;

    logic [XW:0] w_cols;
    logic [YW:0] w_rows;
    gnfs_cfg u_cfg (.*, .o_cols(w_cols), .o_rows(w_rows));

    logic           occ_mem [CELLS];
    logic           vis_mem [CELLS];
    logic [CW-1:0]  q_mem   [CELLS];

    t_state r_st, n_st;
    logic [1:0] r_kind;
    logic [XW-1:0] r_ix, r_x, r_cx;
    logic [YW-1:0] r_iy, r_y, r_cy;
    logic r_occ, r_anti, r_ok;
    logic [2:0] r_first, r_k, r_step;
    logic [QW-1:0] r_head, r_tail, r_clr;
    logic r_res_st;
    logic [XW-1:0] r_res_x;
    logic [YW-1:0] r_res_y;
    logic r_mv;

    // shared occupancy read port
    logic [CW-1:0] w_oaddr;
    logic r_odata, r_vdata;
    logic [CW-1:0] r_qdata;
    logic [CW-1:0] w_vaddr;
    logic w_vwe, w_vwd;
    logic w_owe, w_owd;
    logic [CW-1:0] w_owaddr;
    logic w_qwe;
    logic w_push;

    always_ff @(posedge i_clk) begin
        r_odata <= occ_mem[w_oaddr];
        if (w_owe) occ_mem[w_owaddr] <= w_owd;
    end
    always_ff @(posedge i_clk) begin
        r_vdata <= vis_mem[w_vaddr];
        if (w_vwe) vis_mem[w_vaddr] <= w_vwd;
    end
    always_ff @(posedge i_clk) begin
        r_qdata <= q_mem[r_head[CW-1:0]];
        if (w_qwe) q_mem[r_tail[CW-1:0]] <= {r_cy, r_cx};
    end

    // occupancy map needs clearing after reset
    logic r_init;

    // block cell selection: r_step 0..3 address cells, 1..4 check data
    logic [XW-1:0] w_bx;
    logic [YW-1:0] w_by;
    logic w_bfit;
    assign w_bx = r_x + XW'(r_step[0]);
    assign w_by = r_y + YW'(r_step[1]);
    assign w_bfit = ({1'b0, r_x} + 1'b1 < w_cols) && ({1'b0, r_y} + 1'b1 < w_rows);

    // neighbour under test
    logic [2:0] w_r;
    logic [1:0] w_dx, w_dy;
    logic w_nok;
    logic [XW-1:0] w_nx;
    logic [YW-1:0] w_ny;
    assign w_r  = r_anti ? r_first - r_k : r_first + r_k;
    assign w_dx = ring_dx(w_r);
    assign w_dy = ring_dy(w_r);
    assign w_nok = !(w_dx == 2'd2 && r_x == '0) &&
                   !(w_dx == 2'd1 && ({1'b0, r_x} + 1'b1 >= w_cols)) &&
                   !(w_dy == 2'd2 && r_y == '0) &&
                   !(w_dy == 2'd1 && ({1'b0, r_y} + 1'b1 >= w_rows));
    assign w_nx = (w_dx == 2'd2) ? r_x - 1'b1 : (w_dx == 2'd1) ? r_x + 1'b1 : r_x;
    assign w_ny = (w_dy == 2'd2) ? r_y - 1'b1 : (w_dy == 2'd1) ? r_y + 1'b1 : r_y;

    // start cell goes in unconditionally, the visited map was just cleared
    assign w_push = (r_st == S_NBCHK) && (!r_vdata || r_tail == '0) &&
                    (r_tail < QW'(CELLS));

    always_comb begin
        w_oaddr  = {w_by, w_bx};
        w_owe    = 1'b0;
        w_owd    = 1'b0;
        w_owaddr = {w_by, w_bx};
        w_vaddr  = {r_cy, r_cx};
        w_vwe    = 1'b0;
        w_vwd    = 1'b0;
        w_qwe    = 1'b0;
        if (!r_init) begin
            w_owe = 1'b1;
            w_owaddr = r_clr[CW-1:0];
        end else if (r_st == S_WR) begin
            w_owaddr = r_kind == K_WRITE ? {r_iy, r_ix} : {w_by, w_bx};
            w_owe = 1'b1;
            w_owd = r_kind == K_WRITE ? r_occ : 1'b1;
        end
        if (r_st == S_CLR) begin
            w_vaddr = r_clr[CW-1:0];
            w_vwe = 1'b1;
        end else if (r_st == S_NB) begin
            w_vaddr = {w_ny, w_nx};
        end else if (w_push) begin
            w_vwe = 1'b1;
            w_vwd = 1'b1;
            w_qwe = 1'b1;
        end
    end

    assign s_tready = r_init && r_st == S_IDLE && !r_mv;
    assign m_tvalid = r_mv;
    assign m_tdata  = {5'd0, r_res_y, r_res_x, r_res_st};

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (s_tready && s_tvalid) begin
                case (s_tdata[1:0])
                    K_WRITE:  n_st = S_WR;
                    K_SEARCH: n_st = S_CLR;
                    K_CLAIM:  n_st = S_BLK;
                    default:  n_st = S_OUT;
                endcase
            end
            default: n_st = r_st;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_init <= 1'b0;
            r_clr  <= '0;
            r_mv   <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (m_tready && r_mv) r_mv <= 1'b0;
            if (!r_init) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == QW'(CELLS - 1)) r_init <= 1'b1;
            end
            case (r_st)
                S_IDLE: if (s_tready && s_tvalid) begin
                    r_kind <= s_tdata[1:0];
                    r_ix <= s_tdata[6:2];
                    r_iy <= s_tdata[11:7];
                    r_x  <= s_tdata[6:2];
                    r_y  <= s_tdata[11:7];
                    r_occ <= s_tdata[12];
                    r_first <= {s_tdata[14:13], 1'b0};
                    r_anti <= s_tdata[15];
                    r_cx <= s_tdata[6:2];
                    r_cy <= s_tdata[11:7];
                    r_res_x <= s_tdata[6:2];
                    r_res_y <= s_tdata[11:7];
                    r_res_st <= 1'b1;
                    r_clr <= '0;
                    r_step <= '0;
                    r_ok <= 1'b1;
                    r_head <= '0;
                    r_tail <= '0;
                    r_st <= n_st;
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == QW'(CELLS - 1)) begin
                        // push start cell
                        r_st <= S_NBCHK;
                        r_k <= 3'd7;
                    end
                end
                S_DEQ: begin
                    if (r_head >= r_tail) begin
                        r_st <= S_OUT;
                    end else begin
                        r_step <= 3'd7;
                        r_st <= S_BLK;
                    end
                end
                S_BLK: begin
                    if (r_step == 3'd7) begin
                        // queue read data now valid
                        r_x <= r_qdata[XW-1:0];
                        r_y <= r_qdata[CW-1:XW];
                        r_head <= r_head + 1'b1;
                        r_step <= '0;
                        r_ok <= 1'b1;
                    end else begin
                        if (r_step != 3'd0 && r_odata) r_ok <= 1'b0;
                        if (r_step == 3'd4) begin
                            r_step <= '0;
                            if (r_ok && !(r_step != 3'd0 && r_odata) && w_bfit) begin
                                if (r_kind == K_CLAIM) r_st <= S_WR;
                                else begin
                                    r_res_st <= 1'b0;
                                    r_res_x <= r_x;
                                    r_res_y <= r_y;
                                    r_st <= S_OUT;
                                end
                            end else if (r_kind == K_CLAIM) begin
                                r_st <= S_OUT;
                            end else begin
                                r_k <= '0;
                                r_st <= S_NB;
                            end
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                S_NB: begin
                    r_cx <= w_nx;
                    r_cy <= w_ny;
                    if (w_nok) r_st <= S_NBCHK;
                    else if (r_k == 3'd7) r_st <= S_DEQ;
                    else r_k <= r_k + 1'b1;
                end
                S_NBCHK: begin
                    if (w_push) r_tail <= r_tail + 1'b1;
                    if (r_k == 3'd7) r_st <= S_DEQ;
                    else begin
                        r_k <= r_k + 1'b1;
                        r_st <= S_NB;
                    end
                end
                S_WR: begin
                    if (r_kind == K_WRITE) begin
                        r_res_st <= 1'b0;
                        r_st <= S_OUT;
                    end else begin
                        r_step <= r_step + 1'b1;
                        if (r_step == 3'd3) begin
                            r_res_st <= 1'b0;
                            r_st <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    r_mv <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
